// File: rtl/core/http_chunked_body_decoder_assert.svh
// Assertion macros used by the chunked body decoder RTL.
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge out of reset.
`define HCBD_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define HCBD_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define HCBD_ASSERT(name, clk, rstn, prop, msg)
`define HCBD_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)

`endif

`endif

// File: rtl/core/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, character codes and byte classification for the chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_GRAVE  = 8'h60;

  localparam logic [7:0] HEX_LOWER_OFS = 8'd87;
  localparam logic [7:0] HEX_UPPER_OFS = 8'd55;
  localparam logic [7:0] HEX_DIGIT_OFS = 8'd48;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // Decoder phases. Trailer phases stand for the state after the last chunk.
  typedef enum logic [19:0] {
    PH_SIZE_FIRST  = 20'h00001,
    PH_SIZE_MORE   = 20'h00002,
    PH_EXT_FIRST   = 20'h00004,
    PH_EXT_NAME    = 20'h00008,
    PH_VAL_FIRST   = 20'h00010,
    PH_VAL_TOKEN   = 20'h00020,
    PH_QUOTED      = 20'h00040,
    PH_QPAIR       = 20'h00080,
    PH_AFTER_QUOTE = 20'h00100,
    PH_HDR_LF      = 20'h00200,
    PH_DATA        = 20'h00400,
    PH_DATA_CR     = 20'h00800,
    PH_DATA_LF     = 20'h01000,
    PT_LINE_START  = 20'h02000,
    PT_NAME        = 20'h04000,
    PT_VALUE       = 20'h08000,
    PT_LF          = 20'h10000,
    PT_END_LF      = 20'h20000,
    PH_DONE        = 20'h40000,
    PH_ERROR       = 20'h80000
  } phase_e;

  // One classified input byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       tchar;
    logic       qdtext;
    logic       text;
    logic       cr;
    logic       lf;
    logic       semi;
    logic       equal;
    logic       quote;
    logic       bslash;
    logic       colon;
  } class_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  function automatic logic is_tchar(input logic [7:0] c);
    logic r;
    r = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
        ((c >= "0") && (c <= "9"));
    case (c)
      "!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", CH_GRAVE, "|", "~":
        r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic class_t classify(input logic [7:0] c);
    class_t r;
    logic [7:0] d;
    d = 8'd0;
    r.is_hex = 1'b1;
    if ((c >= "a") && (c <= "f")) begin
      d = c - HEX_LOWER_OFS;
    end else if ((c >= "A") && (c <= "F")) begin
      d = c - HEX_UPPER_OFS;
    end else if ((c >= "0") && (c <= "9")) begin
      d = c - HEX_DIGIT_OFS;
    end else begin
      r.is_hex = 1'b0;
    end
    r.ch      = c;
    r.hex_val = d[3:0];
    r.tchar   = is_tchar(c);
    r.qdtext  = (c == CH_TAB) || (c == CH_SP) || (c == 8'h21) ||
                ((c >= 8'h23) && (c <= 8'h5B)) || ((c >= 8'h5D) && (c <= 8'h7E)) ||
                (c >= 8'h80);
    r.text    = (c == CH_TAB) || ((c >= 8'h20) && (c <= 8'h7E)) || (c >= 8'h80);
    r.cr      = (c == CH_CR);
    r.lf      = (c == CH_LF);
    r.semi    = (c == CH_SEMI);
    r.equal   = (c == CH_EQUAL);
    r.quote   = (c == CH_QUOTE);
    r.bslash  = (c == CH_BSLASH);
    r.colon   = (c == CH_COLON);
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// HTTP/1.1 chunked transfer decoder: one body byte in, one result out.
//
//   Channel   Direction  Handshake               Payload
//   in        input      in_valid_i / in_stall_o   byte_value_i
//   out       output     out_valid_o / out_stall_i body_valid_o, body_byte_o,
//                                                  status_o, body_total_o
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_data_i (trailer_expected)
//
// One byte per clock sustained while the output is not stalled; a taken byte is
// written into the queue, then the framing state machine pops it and loads the
// output register.
// The framing state machine retires one queued byte per cycle when not stalled.
// Reset clears the phase, chunk size, byte count and queue pointers.
// A stalled output holds its result; the two-entry queue absorbs the stall
// before in_stall_o rises, and in_stall_o falls in the cycle after the output
// stall is released.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_chunked_body_decoder_assert.svh"

module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int unsigned SIZE_BITS  = 31,
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             body_valid_o,
  output logic [7:0]       body_byte_o,
  output logic [1:0]       status_o,
  output logic [31:0]      body_total_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);

  logic   trailer_expected_q;
  logic   push;
  logic   pop;
  class_t push_item;
  class_t pop_item;
  qstat_t q_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trailer_expected_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      trailer_expected_q <= cfg_data_i;
    end
  end

  hcbd_front u_front (
    .in_valid_i   (in_valid_i),
    .byte_value_i (byte_value_i),
    .in_stall_o   (in_stall_o),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  hcbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .stat_o      (q_stat)
  );

  hcbd_back #(
    .SIZE_BITS  (SIZE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .trailer_expected_i (trailer_expected_q),
    .q_stat_i           (q_stat),
    .item_i             (pop_item),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .body_valid_o       (body_valid_o),
    .body_byte_o        (body_byte_o),
    .status_o           (status_o),
    .body_total_o       (body_total_o)
  );

  `HCBD_ASSERT(a_queue_flags, clk_i, rst_ni, !(q_stat.full && q_stat.empty),
               "queue full and empty")
  `HCBD_ASSERT(a_pop_nonempty, clk_i, rst_ni, !pop || !q_stat.empty,
               "pop from empty queue")
  `HCBD_ASSERT(a_data_in_progress, clk_i, rst_ni,
               !(out_valid_o && body_valid_o) || (status_o == ST_RUN),
               "data byte with final status")
  `HCBD_ASSERT_NEXT(a_error_sticky, clk_i, rst_ni,
                    out_valid_o && !out_stall_i && (status_o == ST_ERROR) && pop,
                    status_o == ST_ERROR, "error status not sticky")

endmodule

`default_nettype wire

// File: rtl/core/hcbd_front.sv
// ----------------------------------------------------------------------------
// hcbd_front
// Accepts raw body bytes and classifies them into character classes.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_front
  import hcbd_pkg::*;
(
  input  wire logic       in_valid_i,
  input  wire logic [7:0] byte_value_i,
  output logic            in_stall_o,
  input  wire qstat_t     q_stat_i,
  output logic            push_o,
  output class_t          push_item_o
);

  assign in_stall_o  = q_stat_i.full;
  assign push_o      = in_valid_i && !q_stat_i.full;
  assign push_item_o = classify(byte_value_i);

endmodule

`default_nettype wire

// File: rtl/core/hcbd_queue.sv
// ----------------------------------------------------------------------------
// hcbd_queue
// Short queue of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_queue
  import hcbd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire class_t push_item_i,
  input  wire logic   pop_i,
  output class_t      pop_item_o,
  output qstat_t      stat_o
);

  class_t                  mem_q [QDEPTH];
  logic [QPTR_W-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]         cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  assign pop_item_o   = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// File: rtl/core/hcbd_back.sv
// ----------------------------------------------------------------------------
// hcbd_back
// Chunk framing state machine, data pass-through and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_back
  import hcbd_pkg::*;
#(
  parameter int unsigned SIZE_BITS  = 31,
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        trailer_expected_i,
  input  wire qstat_t      q_stat_i,
  input  wire class_t      item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             body_valid_o,
  output logic [7:0]       body_byte_o,
  output logic [1:0]       status_o,
  output logic [31:0]      body_total_o
);

  phase_e                  state_q, state_d;
  logic [SIZE_BITS-1:0]    rem_q, rem_d;
  logic [COUNT_BITS-1:0]   cnt_q, cnt_d;
  logic                    out_valid_q;
  logic                    body_valid_q;
  logic [7:0]              body_byte_q;
  logic [1:0]              status_q;
  logic [31:0]             total_q;
  logic                    data_vld;
  logic [1:0]              status_d;
  logic [31:0]             total_d;
  logic                    size_ovf;
  logic [SIZE_BITS-1:0]    size_shift;

  assign pop_o = !q_stat_i.empty && (!out_valid_q || !out_stall_i);

  assign size_ovf   = |rem_q[SIZE_BITS-1:SIZE_BITS-4];
  assign size_shift = {rem_q[SIZE_BITS-5:0], item_i.hex_val};

  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    data_vld = 1'b0;
    if (pop_o) begin
      case (state_q)
        PH_SIZE_FIRST: begin
          if (!item_i.is_hex || size_ovf) begin
            state_d = PH_ERROR;
          end else begin
            rem_d   = size_shift;
            state_d = PH_SIZE_MORE;
          end
        end
        PH_SIZE_MORE: begin
          if (item_i.is_hex) begin
            if (size_ovf) begin
              state_d = PH_ERROR;
            end else begin
              rem_d = size_shift;
            end
          end else if (item_i.semi) begin
            state_d = PH_EXT_FIRST;
          end else if (item_i.cr) begin
            state_d = PH_HDR_LF;
          end else begin
            state_d = PH_ERROR;
          end
        end
        PH_EXT_FIRST: begin
          state_d = item_i.tchar ? PH_EXT_NAME : PH_ERROR;
        end
        PH_EXT_NAME, PH_VAL_TOKEN: begin
          if (item_i.equal && (state_q == PH_EXT_NAME)) begin
            state_d = PH_VAL_FIRST;
          end else if (item_i.tchar) begin
            state_d = state_q;
          end else if (item_i.semi) begin
            state_d = PH_EXT_FIRST;
          end else if (item_i.cr) begin
            state_d = PH_HDR_LF;
          end else begin
            state_d = PH_ERROR;
          end
        end
        PH_VAL_FIRST: begin
          if (item_i.quote) begin
            state_d = PH_QUOTED;
          end else begin
            state_d = item_i.tchar ? PH_VAL_TOKEN : PH_ERROR;
          end
        end
        PH_QUOTED: begin
          if (item_i.quote) begin
            state_d = PH_AFTER_QUOTE;
          end else if (item_i.bslash) begin
            state_d = PH_QPAIR;
          end else if (!item_i.qdtext) begin
            state_d = PH_ERROR;
          end
        end
        PH_QPAIR: begin
          state_d = item_i.text ? PH_QUOTED : PH_ERROR;
        end
        PH_AFTER_QUOTE: begin
          if (item_i.semi) begin
            state_d = PH_EXT_FIRST;
          end else if (item_i.cr) begin
            state_d = PH_HDR_LF;
          end else begin
            state_d = PH_ERROR;
          end
        end
        PH_HDR_LF: begin
          if (!item_i.lf) begin
            state_d = PH_ERROR;
          end else if (rem_q != '0) begin
            state_d = PH_DATA;
          end else begin
            state_d = PT_LINE_START;
          end
        end
        PH_DATA: begin
          data_vld = 1'b1;
          if (!(&cnt_q)) begin
            cnt_d = cnt_q + 1'b1;
          end
          rem_d = rem_q - 1'b1;
          if (rem_q == SIZE_BITS'(1)) begin
            state_d = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          state_d = item_i.cr ? PH_DATA_LF : PH_ERROR;
        end
        PH_DATA_LF: begin
          state_d = item_i.lf ? PH_SIZE_FIRST : PH_ERROR;
        end
        PT_LINE_START: begin
          // The register is sampled at the start of every line after the last chunk.
          if (item_i.cr) begin
            state_d = PT_END_LF;
          end else if (trailer_expected_i && item_i.tchar) begin
            state_d = PT_NAME;
          end else begin
            state_d = PH_ERROR;
          end
        end
        PT_NAME: begin
          if (item_i.colon) begin
            state_d = PT_VALUE;
          end else if (!item_i.tchar) begin
            state_d = PH_ERROR;
          end
        end
        PT_VALUE: begin
          if (item_i.cr) begin
            state_d = PT_LF;
          end else if (!item_i.text) begin
            state_d = PH_ERROR;
          end
        end
        PT_LF: begin
          state_d = item_i.lf ? PT_LINE_START : PH_ERROR;
        end
        PT_END_LF: begin
          state_d = item_i.lf ? PH_DONE : PH_ERROR;
        end
        PH_DONE: begin
          state_d = PH_DONE;
        end
        PH_ERROR: begin
          state_d = PH_ERROR;
        end
        default: begin
          state_d = PH_ERROR;
        end
      endcase
    end
  end

  always_comb begin
    status_d = ST_RUN;
    if (state_d == PH_DONE) begin
      status_d = ST_DONE;
    end else if (state_d == PH_ERROR) begin
      status_d = ST_ERROR;
    end
  end

  if (COUNT_BITS > 32) begin : g_total_sat
    assign total_d = (|cnt_d[COUNT_BITS-1:32]) ? '1 : cnt_d[31:0];
  end else if (COUNT_BITS == 32) begin : g_total_eq
    assign total_d = cnt_d;
  end else begin : g_total_ext
    assign total_d = {{(32-COUNT_BITS){1'b0}}, cnt_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PH_SIZE_FIRST;
      rem_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      body_valid_q <= data_vld;
      body_byte_q  <= data_vld ? item_i.ch : 8'd0;
      status_q     <= status_d;
      total_q      <= total_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign body_valid_o = body_valid_q;
  assign body_byte_o  = body_byte_q;
  assign status_o     = status_q;
  assign body_total_o = total_q;

endmodule

`default_nettype wire
